### rtl/core/tasp_pkg.sv
// ----------------------------------------------------------------------------
// tasp_pkg: shared types and constants of the tar archive stream parser.
// Holds the event codes, the header field offsets and the queue entry format
// that passes between the front and back halves of the parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tasp_pkg;

    // Default width of the internal size and byte-count registers.
    localparam int SIZE_BITS_DEF = 36;

    // Width of the entry size on the result channel.
    localparam int OUT_SIZE_W = 36;

    // Depth of the queue between the front and the back.
    localparam int Q_DEPTH = 4;

    // Header block layout.
    localparam logic [8:0] OFF_SIZE_FIRST = 9'd124;
    localparam logic [8:0] OFF_SIZE_LAST  = 9'd135;
    localparam logic [8:0] OFF_SUM_FIRST  = 9'd148;
    localparam logic [8:0] OFF_SUM_LAST   = 9'd155;
    localparam logic [8:0] OFF_TYPE       = 9'd156;
    localparam logic [8:0] OFF_BLOCK_LAST = 9'd511;

    // Character codes.
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_SEVEN = 8'h37;
    localparam logic [7:0] CHR_DIR   = 8'h35;
    localparam logic [7:0] CHR_NUL   = 8'h00;

    // Result event codes.
    typedef enum logic [2:0] {
        EV_PAYLOAD   = 3'd0,
        EV_FILE      = 3'd1,
        EV_DIR       = 3'd2,
        EV_OTHER     = 3'd3,
        EV_END       = 3'd4,
        EV_CSUM_FAIL = 3'd5,
        EV_TRUNC     = 3'd6
    } t_event;

    // Region of the header block that a byte falls into.
    typedef enum logic [1:0] {
        RG_PLAIN = 2'd0,
        RG_SIZE  = 2'd1,
        RG_SUM   = 2'd2,
        RG_TYPE  = 2'd3
    } t_region;

    // One classified input transfer, as held in the queue.
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
        t_region    region;
        logic       blk_end;
    } t_q_entry;

endpackage

### rtl/core/tasp_if.sv
// ----------------------------------------------------------------------------
// tasp_if: stream interfaces of the tar archive stream parser.
// The byte channel carries archive bytes and the end-of-input mark; the event
// channel carries parse results. Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tasp_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] archive_byte;

    modport source (output valid, output cmd, output archive_byte, input ready);
    modport sink   (input valid, input cmd, input archive_byte, output ready);
endinterface

interface tasp_out_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      event_res;
    logic [7:0]                      payload_byte;
    logic [tasp_pkg::OUT_SIZE_W-1:0] entry_size;
    logic                            last_of_entry;

    modport source (output valid, output event_res, output payload_byte,
                    output entry_size, output last_of_entry, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input entry_size, input last_of_entry, output ready);
endinterface

### rtl/core/tasp_front.sv
// ----------------------------------------------------------------------------
// tasp_front: input side of the tar archive stream parser.
// Accepts byte transfers, tracks the position within the 512-byte block and
// tags each byte with the header region it belongs to.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tasp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    tasp_in_if.sink             i_byte_in,
    input  logic                i_q_full,
    output logic                o_q_push,
    output tasp_pkg::t_q_entry  o_q_entry
);

    logic [8:0]        r_offset;
    logic [8:0]        n_offset;
    tasp_pkg::t_region w_region;

    // A transfer is taken whenever the queue has room.
    assign i_byte_in.ready = !i_q_full;
    assign o_q_push        = i_byte_in.valid && !i_q_full;

    // Header region of the current offset.
    always_comb begin
        if (r_offset inside {[tasp_pkg::OFF_SIZE_FIRST:tasp_pkg::OFF_SIZE_LAST]}) begin
            w_region = tasp_pkg::RG_SIZE;
        end else if (r_offset inside {[tasp_pkg::OFF_SUM_FIRST:tasp_pkg::OFF_SUM_LAST]}) begin
            w_region = tasp_pkg::RG_SUM;
        end else if (r_offset == tasp_pkg::OFF_TYPE) begin
            w_region = tasp_pkg::RG_TYPE;
        end else begin
            w_region = tasp_pkg::RG_PLAIN;
        end
    end

    assign o_q_entry.cmd     = i_byte_in.cmd;
    assign o_q_entry.data    = i_byte_in.archive_byte;
    assign o_q_entry.region  = w_region;
    assign o_q_entry.blk_end = (r_offset == tasp_pkg::OFF_BLOCK_LAST);

    // The block offset counts every archive byte and wraps every 512 bytes.
    always_comb begin
        n_offset = r_offset;
        if (o_q_push && !i_byte_in.cmd) begin
            n_offset = r_offset + 9'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
        end else begin
            r_offset <= n_offset;
        end
    end

endmodule

### rtl/core/tasp_queue.sv
// ----------------------------------------------------------------------------
// tasp_queue: short queue between the front and back of the parser.
// Holds classified byte transfers so that a stall on the result side does
// not immediately stop the input side.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tasp_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  tasp_pkg::t_q_entry  i_entry,
    input  logic                i_pop,
    output logic                o_full,
    output logic                o_valid,
    output tasp_pkg::t_q_entry  o_entry
);

    localparam int PtrW = (tasp_pkg::Q_DEPTH > 1) ? $clog2(tasp_pkg::Q_DEPTH) : 1;
    localparam int CntW = $clog2(tasp_pkg::Q_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(tasp_pkg::Q_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(tasp_pkg::Q_DEPTH);

    tasp_pkg::t_q_entry r_mem [tasp_pkg::Q_DEPTH];
    logic [PtrW-1:0]    r_wr_ptr;
    logic [PtrW-1:0]    r_rd_ptr;
    logic [CntW-1:0]    r_count;
    logic [PtrW-1:0]    n_wr_ptr;
    logic [PtrW-1:0]    n_rd_ptr;
    logic [CntW-1:0]    n_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_full    = (r_count == CntFull);
    assign o_valid   = (r_count != '0);
    assign o_entry   = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    // Pointer and fill-level update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PtrLast) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrLast) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CntW'(1);
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

endmodule

### rtl/core/tasp_back.sv
// ----------------------------------------------------------------------------
// tasp_back: execution side of the tar archive stream parser.
// Walks header blocks (checksum, octal size and checksum fields, type byte),
// counts payload bytes of each entry and drives the registered event output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tasp_back #(
    parameter int SIZE_BITS = tasp_pkg::SIZE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  tasp_pkg::t_q_entry  i_q_entry,
    output logic                o_q_pop,
    tasp_out_if.source          o_event_out
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_DATA   = 2'd1,
        PH_HALT   = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        OCT_SKIP   = 2'd0,
        OCT_DIGITS = 2'd1,
        OCT_STOP   = 2'd2
    } t_oct_mode;

    t_phase                          r_phase,     n_phase;
    logic [16:0]                     r_sum,       n_sum;
    logic                            r_all_zero,  n_all_zero;
    logic [23:0]                     r_sum_val,   n_sum_val;
    t_oct_mode                       r_sum_mode,  n_sum_mode;
    logic [SIZE_BITS-1:0]            r_size_val,  n_size_val;
    t_oct_mode                       r_size_mode, n_size_mode;
    logic [7:0]                      r_type,      n_type;
    logic [SIZE_BITS-1:0]            r_left,      n_left;
    logic                            r_emit_en,   n_emit_en;

    logic                            r_out_valid, n_out_valid;
    tasp_pkg::t_event                r_out_event, n_out_event;
    logic [7:0]                      r_out_byte,  n_out_byte;
    logic [tasp_pkg::OUT_SIZE_W-1:0] r_out_size,  n_out_size;
    logic                            r_out_last,  n_out_last;

    logic                            w_take;
    logic [7:0]                      w_b;
    logic                            w_digit;
    logic [SIZE_BITS-1:0]            w_entry_sz;
    logic [63:0]                     w_sz_ext;

    // The next queued transfer is taken whenever the output register is free.
    assign w_take  = i_q_valid && (!r_out_valid || o_event_out.ready);
    assign o_q_pop = w_take;

    assign w_b     = i_q_entry.data;
    assign w_digit = (w_b >= tasp_pkg::CHR_ZERO) && (w_b <= tasp_pkg::CHR_SEVEN);

    // Size reported with a header: directories count as empty.
    assign w_entry_sz = (r_type == tasp_pkg::CHR_DIR) ? '0 : r_size_val;
    assign w_sz_ext   = 64'(w_entry_sz);

    always_comb begin
        n_phase     = r_phase;
        n_sum       = r_sum;
        n_all_zero  = r_all_zero;
        n_sum_val   = r_sum_val;
        n_sum_mode  = r_sum_mode;
        n_size_val  = r_size_val;
        n_size_mode = r_size_mode;
        n_type      = r_type;
        n_left      = r_left;
        n_emit_en   = r_emit_en;

        n_out_valid = r_out_valid;
        n_out_event = r_out_event;
        n_out_byte  = r_out_byte;
        n_out_size  = r_out_size;
        n_out_last  = r_out_last;

        // A completed output transfer empties the register.
        if (o_event_out.ready) begin
            n_out_valid = 1'b0;
        end

        if (w_take && r_phase != PH_HALT) begin
            n_out_valid = 1'b0;
            n_out_byte  = '0;
            n_out_size  = '0;
            n_out_last  = 1'b0;

            if (i_q_entry.cmd) begin
                // Input ended before the archive did.
                n_phase     = PH_HALT;
                n_out_valid = 1'b1;
                n_out_event = tasp_pkg::EV_TRUNC;
            end else if (r_phase == PH_HEADER) begin
                if (w_b != '0) begin
                    n_all_zero = 1'b0;
                end

                // Checksum field counts as spaces and is parsed as octal.
                if (i_q_entry.region == tasp_pkg::RG_SUM) begin
                    n_sum = r_sum + 17'(tasp_pkg::CHR_SPACE);
                    case (r_sum_mode)
                        OCT_SKIP: begin
                            if (w_digit) begin
                                n_sum_val  = 24'(w_b[2:0]);
                                n_sum_mode = OCT_DIGITS;
                            end
                        end
                        OCT_DIGITS: begin
                            if (w_digit) begin
                                n_sum_val = {r_sum_val[20:0], w_b[2:0]};
                            end else begin
                                n_sum_mode = OCT_STOP;
                            end
                        end
                        default: n_sum_mode = OCT_STOP;
                    endcase
                end else begin
                    n_sum = r_sum + 17'(w_b);
                end

                // Size field parsed as octal, wrapping at the register width.
                if (i_q_entry.region == tasp_pkg::RG_SIZE) begin
                    case (r_size_mode)
                        OCT_SKIP: begin
                            if (w_digit) begin
                                n_size_val  = SIZE_BITS'(w_b[2:0]);
                                n_size_mode = OCT_DIGITS;
                            end
                        end
                        OCT_DIGITS: begin
                            if (w_digit) begin
                                n_size_val = {r_size_val[SIZE_BITS-4:0], w_b[2:0]};
                            end else begin
                                n_size_mode = OCT_STOP;
                            end
                        end
                        default: n_size_mode = OCT_STOP;
                    endcase
                end

                if (i_q_entry.region == tasp_pkg::RG_TYPE) begin
                    n_type = w_b;
                end

                // Last byte of the header block: decide what it was.
                if (i_q_entry.blk_end) begin
                    n_out_valid = 1'b1;
                    if (n_all_zero) begin
                        n_phase     = PH_HALT;
                        n_out_event = tasp_pkg::EV_END;
                    end else if (24'(n_sum) != r_sum_val) begin
                        n_phase     = PH_HALT;
                        n_out_event = tasp_pkg::EV_CSUM_FAIL;
                    end else begin
                        if (r_type == tasp_pkg::CHR_DIR) begin
                            n_out_event = tasp_pkg::EV_DIR;
                            n_emit_en   = 1'b0;
                        end else if (r_type == tasp_pkg::CHR_ZERO ||
                                     r_type == tasp_pkg::CHR_NUL) begin
                            n_out_event = tasp_pkg::EV_FILE;
                            n_emit_en   = 1'b1;
                        end else begin
                            n_out_event = tasp_pkg::EV_OTHER;
                            n_emit_en   = 1'b0;
                        end
                        n_out_size  = w_sz_ext[tasp_pkg::OUT_SIZE_W-1:0];
                        n_left      = w_entry_sz;
                        n_phase     = (w_entry_sz != '0) ? PH_DATA : PH_HEADER;
                        n_sum       = '0;
                        n_all_zero  = 1'b1;
                        n_sum_val   = '0;
                        n_sum_mode  = OCT_SKIP;
                        n_size_val  = '0;
                        n_size_mode = OCT_SKIP;
                        n_type      = '0;
                    end
                end
            end else begin
                // Data block: count the payload, the rest is padding.
                if (r_left != '0) begin
                    n_left = r_left - SIZE_BITS'(1);
                    if (r_emit_en) begin
                        n_out_valid = 1'b1;
                        n_out_event = tasp_pkg::EV_PAYLOAD;
                        n_out_byte  = w_b;
                        n_out_last  = (r_left == SIZE_BITS'(1));
                    end
                end
                if (i_q_entry.blk_end && n_left == '0) begin
                    n_phase     = PH_HEADER;
                    n_sum       = '0;
                    n_all_zero  = 1'b1;
                    n_sum_val   = '0;
                    n_sum_mode  = OCT_SKIP;
                    n_size_val  = '0;
                    n_size_mode = OCT_SKIP;
                    n_type      = '0;
                end
            end
        end
    end

    // Parser state and the registered output.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_sum       <= '0;
            r_all_zero  <= 1'b1;
            r_sum_val   <= '0;
            r_sum_mode  <= OCT_SKIP;
            r_size_val  <= '0;
            r_size_mode <= OCT_SKIP;
            r_type      <= '0;
            r_left      <= '0;
            r_emit_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_sum       <= n_sum;
            r_all_zero  <= n_all_zero;
            r_sum_val   <= n_sum_val;
            r_sum_mode  <= n_sum_mode;
            r_size_val  <= n_size_val;
            r_size_mode <= n_size_mode;
            r_type      <= n_type;
            r_left      <= n_left;
            r_emit_en   <= n_emit_en;
            r_out_valid <= n_out_valid;
        end
        r_out_event <= n_out_event;
        r_out_byte  <= n_out_byte;
        r_out_size  <= n_out_size;
        r_out_last  <= n_out_last;
    end

    assign o_event_out.valid         = r_out_valid;
    assign o_event_out.event_res     = r_out_event;
    assign o_event_out.payload_byte  = r_out_byte;
    assign o_event_out.entry_size    = r_out_size;
    assign o_event_out.last_of_entry = r_out_last;

endmodule

### rtl/core/tar_archive_stream_parser_core.sv
// ----------------------------------------------------------------------------
// tar_archive_stream_parser_core: streaming tar (ustar) archive parser.
// Usage:
//   i_byte_in carries one archive byte per transfer (cmd 0) or the end of the
//   input (cmd 1). o_event_out carries header events with the entry size,
//   payload bytes of regular files with a last-byte flag, and the final
//   end, checksum-failure or truncation event.
//   One byte is taken per cycle while the queue has room. A result passes
//   through the classification queue and then the output register. Header
//   bytes other than the last of a block, and padding, give no result.
//   A four-entry queue separates the byte counter and classifier from the
//   parsing unit, so a stalled receiver holds the output register while up
//   to four further bytes are still taken; after that i_byte_in.ready drops.
//   After the end, a checksum failure or truncation the parser is halted:
//   bytes are still taken but give no result until reset.
//   Reset (synchronous, active low) empties the queue and the output and
//   returns the parser to the start of a header block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tar_archive_stream_parser_core #(
    parameter int SIZE_BITS = tasp_pkg::SIZE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tasp_in_if.sink     i_byte_in,
    tasp_out_if.source  o_event_out
);

    logic               w_q_push;
    logic               w_q_pop;
    logic               w_q_full;
    logic               w_q_valid;
    tasp_pkg::t_q_entry w_push_entry;
    tasp_pkg::t_q_entry w_pop_entry;

    // Byte counter and region classifier.
    tasp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_in (i_byte_in),
        .i_q_full  (w_q_full),
        .o_q_push  (w_q_push),
        .o_q_entry (w_push_entry)
    );

    // Decoupling queue.
    tasp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_entry (w_push_entry),
        .i_pop   (w_q_pop),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_entry (w_pop_entry)
    );

    // Header walk, payload counter and output register.
    tasp_back #(
        .SIZE_BITS (SIZE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .i_q_entry   (w_pop_entry),
        .o_q_pop     (w_q_pop),
        .o_event_out (o_event_out)
    );

`ifndef SYNTHESIS
    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_push |-> !w_q_full)
        else $error("queue push while full");

    // The last-byte flag only accompanies a payload byte.
    a_last_is_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_out.valid && o_event_out.last_of_entry) |->
            (o_event_out.event_res == tasp_pkg::EV_PAYLOAD))
        else $error("last flag on a non-payload event");

    // Only file and other headers carry a size.
    a_size_on_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_out.valid && o_event_out.entry_size != '0) |->
            (o_event_out.event_res == tasp_pkg::EV_FILE ||
             o_event_out.event_res == tasp_pkg::EV_OTHER))
        else $error("entry size on an event without size");

    // Once a terminating event has been delivered, nothing follows it.
    a_halt_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_out.valid && o_event_out.ready &&
         (o_event_out.event_res == tasp_pkg::EV_END ||
          o_event_out.event_res == tasp_pkg::EV_CSUM_FAIL ||
          o_event_out.event_res == tasp_pkg::EV_TRUNC)) |=> !o_event_out.valid)
        else $error("result after a terminating event");
`endif

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the tar archive stream parser core.
// Streams an archive into the byte channel and predicts every event with a
// behavioural parser of its own. A regular file entry is sent first, and its
// data block goes in under a long receiver hold-off. The idling pattern moves
// through four phases as the transfers go by. The run finishes with a single
// randomly chosen ending: end of archive, checksum failure or truncated
// input, followed by bytes that the halted parser must ignore.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    localparam int RUN_LIMIT_NS    = 5_000_000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 390;
    localparam int TRAIL_ITEMS     = 20;
    localparam int BLOCK_BYTES     = 512;
    localparam int SIZE_FIELD_LEN  = 12;
    localparam int SUM_FIELD_LEN   = 8;

    typedef enum logic [1:0] {
        WALK_HEADER,
        WALK_DATA,
        WALK_HALT
    } walk_phase_t;

    typedef enum logic [1:0] {
        SCAN_LEAD,
        SCAN_DIGITS,
        SCAN_DONE
    } octal_scan_t;

    typedef enum {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_kind_t;

    typedef enum {
        TERM_END,
        TERM_CSUM,
        TERM_TRUNC
    } term_kind_t;

    typedef enum {
        CUT_BOUNDARY,
        CUT_HEADER,
        CUT_DATA
    } cut_point_t;

    typedef struct packed {
        tasp_pkg::t_event ev;
        logic [7:0]       data;
        logic [35:0]      size;
        logic             is_last;
    } parse_event_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    tasp_in_if  byte_if ();
    tasp_out_if event_if ();

    tar_archive_stream_parser_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_in   (byte_if),
        .o_event_out (event_if)
    );

    // Predicted parser state.
    walk_phase_t  walk_phase;
    logic [8:0]   blk_pos;
    logic [16:0]  hdr_csum;
    logic         hdr_zero;
    logic [23:0]  csum_field;
    octal_scan_t  csum_scan;
    logic [35:0]  size_field;
    octal_scan_t  size_scan;
    logic [7:0]   entry_type;
    logic [35:0]  remain;
    logic         file_open;

    parse_event_t pending_events[$];
    logic [7:0]   hdr_buf [0:BLOCK_BYTES-1];

    // Size of the regular file entry shared by the first two tests.
    logic [35:0]  file_size;

    int error_count   = 0;
    int items_sent    = 0;
    int src_idle_pct  = 0;
    int snk_stall_pct = 0;
    int hold_cycles   = 0;
    int drain_wait    = 0;

    // Free-running clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Overall time limit.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit is_octal(input logic [7:0] c);
        return (c >= tasp_pkg::CHR_ZERO) && (c <= tasp_pkg::CHR_SEVEN);
    endfunction

    function automatic logic [7:0] rand_non_octal();
        logic [7:0] c;
        c = rand_byte();
        while (is_octal(c)) c = rand_byte();
        return c;
    endfunction

    function automatic logic [7:0] fill_byte(input fill_kind_t fill);
        if (fill == FILL_ONES) return 8'hFF;
        if (fill == FILL_ZEROS) return 8'h00;
        return rand_byte();
    endfunction

    // Picks a type byte: mostly regular files, some directories and others.
    function automatic logic [7:0] rand_type();
        int         pick;
        logic [7:0] c;
        pick = $urandom_range(0, 9);
        if (pick < 5) return tasp_pkg::CHR_ZERO;
        if (pick == 5) return tasp_pkg::CHR_NUL;
        if (pick < 8) return tasp_pkg::CHR_DIR;
        c = rand_byte();
        while (c == tasp_pkg::CHR_ZERO || c == tasp_pkg::CHR_NUL || c == tasp_pkg::CHR_DIR)
            c = rand_byte();
        return c;
    endfunction

    // Next mode of an octal field scan.
    function automatic octal_scan_t scan_step(input octal_scan_t mode, input logic [7:0] c);
        if (mode == SCAN_DONE) return SCAN_DONE;
        if (is_octal(c)) return SCAN_DIGITS;
        if (mode == SCAN_LEAD) return SCAN_LEAD;
        return SCAN_DONE;
    endfunction

    // Next value of an octal field scan; digits beyond the width fall off.
    function automatic logic [35:0] scan_value(input octal_scan_t mode,
                                               input logic [35:0] value,
                                               input logic [7:0] c);
        if (!is_octal(c) || mode == SCAN_DONE) return value;
        if (mode == SCAN_LEAD) return {33'd0, c[2:0]};
        return {value[32:0], c[2:0]};
    endfunction

    task automatic clear_header();
        blk_pos    = '0;
        hdr_csum   = '0;
        hdr_zero   = 1'b1;
        csum_field = '0;
        csum_scan  = SCAN_LEAD;
        size_field = '0;
        size_scan  = SCAN_LEAD;
        entry_type = '0;
    endtask

    task automatic push_event(input tasp_pkg::t_event ev, input logic [7:0] data,
                              input logic [35:0] size, input logic is_last);
        parse_event_t item;
        item.ev      = ev;
        item.data    = data;
        item.size    = size;
        item.is_last = is_last;
        pending_events.push_back(item);
    endtask

    // Advances the predicted parser by one accepted transfer.
    task automatic predict_parse_events(input logic cmd, input logic [7:0] b);
        logic [8:0]       pos;
        logic [35:0]      acc;
        logic [35:0]      sz;
        tasp_pkg::t_event ev;
        logic             is_last;
        if (walk_phase == WALK_HALT) return;
        if (cmd) begin
            walk_phase = WALK_HALT;
            push_event(tasp_pkg::EV_TRUNC, 8'h00, '0, 1'b0);
            return;
        end
        pos = blk_pos;

        if (walk_phase == WALK_HEADER) begin
            if (b != 8'h00) hdr_zero = 1'b0;
            // The checksum field itself counts as spaces.
            if (pos >= tasp_pkg::OFF_SUM_FIRST && pos <= tasp_pkg::OFF_SUM_LAST) begin
                hdr_csum   = hdr_csum + {9'd0, tasp_pkg::CHR_SPACE};
                acc        = scan_value(csum_scan, {12'd0, csum_field}, b);
                csum_field = acc[23:0];
                csum_scan  = scan_step(csum_scan, b);
            end else begin
                hdr_csum = hdr_csum + {9'd0, b};
            end
            if (pos >= tasp_pkg::OFF_SIZE_FIRST && pos <= tasp_pkg::OFF_SIZE_LAST) begin
                size_field = scan_value(size_scan, size_field, b);
                size_scan  = scan_step(size_scan, b);
            end
            if (pos == tasp_pkg::OFF_TYPE) entry_type = b;
            if (pos != tasp_pkg::OFF_BLOCK_LAST) begin
                blk_pos = pos + 9'd1;
                return;
            end

            // Last header byte: the zero-block test goes before the checksum.
            if (hdr_zero) begin
                walk_phase = WALK_HALT;
                push_event(tasp_pkg::EV_END, 8'h00, '0, 1'b0);
            end else if ({7'd0, hdr_csum} != csum_field) begin
                walk_phase = WALK_HALT;
                push_event(tasp_pkg::EV_CSUM_FAIL, 8'h00, '0, 1'b0);
            end else begin
                sz = size_field;
                if (entry_type == tasp_pkg::CHR_DIR) begin
                    ev        = tasp_pkg::EV_DIR;
                    sz        = '0;
                    file_open = 1'b0;
                end else if (entry_type == tasp_pkg::CHR_ZERO ||
                             entry_type == tasp_pkg::CHR_NUL) begin
                    ev        = tasp_pkg::EV_FILE;
                    file_open = 1'b1;
                end else begin
                    ev        = tasp_pkg::EV_OTHER;
                    file_open = 1'b0;
                end
                remain = sz;
                clear_header();
                walk_phase = (sz != 0) ? WALK_DATA : WALK_HEADER;
                push_event(ev, 8'h00, sz, 1'b0);
            end
            return;
        end

        // Data blocks: payload of regular files, everything else is skipped.
        if (remain != 0) begin
            is_last = (remain == 36'd1);
            remain  = remain - 36'd1;
            if (file_open) push_event(tasp_pkg::EV_PAYLOAD, b, '0, is_last);
        end
        if (pos == tasp_pkg::OFF_BLOCK_LAST) begin
            blk_pos = '0;
            if (remain == 0) begin
                clear_header();
                walk_phase = WALK_HEADER;
            end
        end else begin
            blk_pos = pos + 9'd1;
        end
    endtask

    task automatic set_idle(input idle_mode_t mode);
        src_idle_pct  = (mode == IDLE_SENDER || mode == IDLE_BOTH) ?
                        ((mode == IDLE_BOTH) ? 15 : 70) : 0;
        snk_stall_pct = (mode == IDLE_RECEIVER || mode == IDLE_BOTH) ?
                        ((mode == IDLE_BOTH) ? 15 : 70) : 0;
    endtask

    // Offers one transfer, with random idle cycles before it, and waits for it.
    // The idling pattern follows the number of transfers sent so far.
    task automatic send_item(input logic cmd, input logic [7:0] b);
        int phase;
        phase = items_sent / PHASE_ITEMS;
        if (phase > 3) phase = 3;
        set_idle(idle_mode_t'(phase));
        @(negedge i_clk);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            byte_if.valid        <= 1'b0;
            byte_if.archive_byte <= rand_byte();
            @(negedge i_clk);
        end
        byte_if.valid        <= 1'b1;
        byte_if.cmd          <= cmd;
        byte_if.archive_byte <= b;
        @(posedge i_clk);
        while (!byte_if.ready) @(posedge i_clk);
        items_sent++;
        predict_parse_events(cmd, b);
    endtask

    // Writes an octal number into a header field with a random layout:
    // leading non-digits, zero-padded digits, a terminator and trailing junk.
    task automatic write_octal_field(input int start, input int width,
                                     input logic [35:0] value, input bit no_digits);
        int          n;
        int          lead;
        int          ndig;
        int          p;
        int          k;
        logic [35:0] v;
        logic [35:0] digit;
        if (no_digits) begin
            for (p = 0; p < width; p++) hdr_buf[start + p] = rand_non_octal();
            return;
        end
        n = 1;
        v = value >> 3;
        while (v != 0) begin
            n++;
            v = v >> 3;
        end
        if (n <= width - 1 && $urandom_range(0, 1)) begin
            lead = 0;
            ndig = width - 1;
        end else begin
            lead = $urandom_range(0, width - n);
            ndig = $urandom_range(n, width - lead);
        end
        for (p = 0; p < lead; p++) hdr_buf[start + p] = rand_non_octal();
        for (k = 0; k < ndig; k++) begin
            digit = value >> (3 * (ndig - 1 - k));
            hdr_buf[start + lead + k] = {5'b00110, digit[2:0]};
        end
        p = start + lead + ndig;
        if (p < start + width) begin
            hdr_buf[p] = rand_non_octal();
            for (p = p + 1; p < start + width; p++) hdr_buf[p] = rand_byte();
        end
    endtask

    // Fills the header buffer, with a correct checksum unless bad_sum is set.
    task automatic build_header(input logic [7:0] type_byte, input logic [35:0] size,
                                input fill_kind_t fill, input bit bad_sum);
        logic [16:0] sum;
        logic [23:0] stored;
        int          i;
        for (i = 0; i < BLOCK_BYTES; i++) hdr_buf[i] = fill_byte(fill);
        write_octal_field(int'(tasp_pkg::OFF_SIZE_FIRST), SIZE_FIELD_LEN, size,
                          (size == 0) && ($urandom_range(0, 1) == 1));
        hdr_buf[tasp_pkg::OFF_TYPE] = type_byte;
        sum = '0;
        for (i = 0; i < BLOCK_BYTES; i++) begin
            if (i >= tasp_pkg::OFF_SUM_FIRST && i <= tasp_pkg::OFF_SUM_LAST)
                sum = sum + {9'd0, tasp_pkg::CHR_SPACE};
            else
                sum = sum + {9'd0, hdr_buf[i]};
        end
        stored = {7'd0, sum};
        if (bad_sum && $urandom_range(0, 1)) begin
            // No digits at all reads as zero, which never matches.
            write_octal_field(int'(tasp_pkg::OFF_SUM_FIRST), SUM_FIELD_LEN, '0, 1'b1);
        end else begin
            if (bad_sum) stored = stored ^ (24'd1 << $urandom_range(0, 16));
            write_octal_field(int'(tasp_pkg::OFF_SUM_FIRST), SUM_FIELD_LEN,
                              {12'd0, stored}, 1'b0);
        end
    endtask

    task automatic send_header(input int count);
        int i;
        for (i = 0; i < count; i++) send_item(1'b0, hdr_buf[i]);
    endtask

    // Sends the data blocks of an entry, padded to a whole block.
    task automatic send_data(input logic [35:0] size, input fill_kind_t fill);
        logic [35:0] total;
        logic [35:0] i;
        total = ((size + 36'd511) >> 9) << 9;
        for (i = 0; i < total; i++)
            send_item(1'b0, (i < size) ? fill_byte(fill) : rand_byte());
    endtask

    function automatic fill_kind_t rand_fill();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 6) return FILL_ONES;
        if (pick == 7) return FILL_ZEROS;
        return FILL_RANDOM;
    endfunction

    // Header of a regular file whose data fits in one block.
    task automatic test_file_header();
        logic [7:0] type_byte;
        type_byte = ($urandom_range(0, 1) == 1) ? tasp_pkg::CHR_ZERO : tasp_pkg::CHR_NUL;
        file_size = 36'($urandom_range(1, BLOCK_BYTES));
        build_header(type_byte, file_size, rand_fill(), 1'b0);
        send_header(BLOCK_BYTES);
    endtask

    // The receiver holds off while payload keeps coming, so the input stalls.
    task automatic test_payload_back_pressure();
        hold_cycles = HOLD_OFF_CYCLES;
        send_data(file_size, rand_fill());
    endtask

    // Ends the archive one of three ways, then checks that the halt holds.
    task automatic test_termination();
        term_kind_t  kind;
        cut_point_t  cut;
        logic [35:0] size;
        int          count;
        int          i;
        kind = term_kind_t'($urandom_range(0, 2));
        case (kind)
            TERM_END: begin
                for (i = 0; i < BLOCK_BYTES; i++) send_item(1'b0, 8'h00);
            end
            TERM_CSUM: begin
                build_header(rand_type(), 36'($urandom_range(0, 600)), rand_fill(), 1'b1);
                send_header(BLOCK_BYTES);
            end
            default: begin
                cut = cut_point_t'($urandom_range(0, 2));
                if (cut == CUT_HEADER) begin
                    build_header(rand_type(), 36'($urandom_range(0, 600)), FILL_RANDOM, 1'b0);
                    send_header($urandom_range(1, BLOCK_BYTES - 1));
                end else if (cut == CUT_DATA) begin
                    count = $urandom_range(2, 300);
                    size  = 36'(count);
                    build_header(rand_type(), size, FILL_RANDOM, 1'b0);
                    send_header(BLOCK_BYTES);
                    count = $urandom_range(1, count - 1);
                    for (i = 0; i < count; i++) send_item(1'b0, rand_byte());
                end
                send_item(1'b1, rand_byte());
            end
        endcase
        for (i = 0; i < TRAIL_ITEMS; i++) send_item(1'($urandom_range(0, 1)), rand_byte());
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            event_if.ready <= 1'b0;
            hold_cycles--;
        end else begin
            event_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    task automatic compare_field(input string name, input logic [35:0] want,
                                 input logic [35:0] got);
        if (want !== got) begin
            error_count++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // Checks each result transfer against the oldest prediction.
    always @(posedge i_clk) begin : check_events
        parse_event_t want;
        if (i_rst_n && event_if.valid && event_if.ready) begin
            if (pending_events.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result: expected none, actual event %0d %s",
                         $time, event_if.event_res,
                         $sformatf("byte %0h size %0h last %0b", event_if.payload_byte,
                                   event_if.entry_size, event_if.last_of_entry));
            end else begin
                want = pending_events.pop_front();
                compare_field("event", {33'd0, want.ev}, {33'd0, event_if.event_res});
                compare_field("payload byte", {28'd0, want.data},
                              {28'd0, event_if.payload_byte});
                compare_field("entry size", want.size, event_if.entry_size);
                compare_field("last of entry", {35'd0, want.is_last},
                              {35'd0, event_if.last_of_entry});
            end
        end
    end

    initial begin
        byte_if.valid        = 1'b0;
        byte_if.cmd          = 1'b0;
        byte_if.archive_byte = 8'h00;
        event_if.ready       = 1'b0;
        walk_phase           = WALK_HEADER;
        clear_header();
        remain               = '0;
        file_open            = 1'b0;
        file_size            = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_file_header();
        test_payload_back_pressure();
        test_termination();

        @(negedge i_clk);
        byte_if.valid <= 1'b0;
        set_idle(IDLE_NONE);
        while (pending_events.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain_wait++;
        end
        if (pending_events.size() != 0) begin
            error_count++;
            $display("%0t: result count mismatch: expected %0d more results, actual 0",
                     $time, pending_events.size());
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
